FILE: rtl/fljo_pkg.sv
// Shared types, codes and a helper function for the lepton-jet overlap filter.
package fljo_pkg;

    // Item kinds carried on the mode field.
    typedef enum logic [1:0] {
        MODE_ELECTRON = 2'd0,
        MODE_MUON     = 2'd1,
        MODE_JET      = 2'd2,
        MODE_END      = 2'd3
    } mode_t;

    // Configuration register indices.
    typedef enum logic [2:0] {
        CFG_ELE_PT_MIN  = 3'd0,
        CFG_ELE_ETA_MAX = 3'd1,
        CFG_MU_PT_MIN   = 3'd2,
        CFG_MU_ETA_MAX  = 3'd3,
        CFG_ELE_RADIUS  = 3'd4,
        CFG_MU_RADIUS   = 3'd5,
        CFG_OVERLAP_EN  = 3'd6
    } cfg_index_t;

    // Angles in units of 1/4096 rad.
    localparam logic signed [16:0] PHI_PI     = 17'sd12868;
    localparam logic signed [16:0] PHI_TWO_PI = 17'sd25736;

    // One stored lepton.
    typedef struct packed {
        logic               is_muon;
        logic signed [15:0] eta;
        logic signed [14:0] phi;
    } lepton_t;

    // Jet token travelling along the cell chain, with the squared distance
    // to the lepton of the cell that produced it, still to be compared.
    typedef struct packed {
        logic               valid;
        logic signed [15:0] eta;
        logic signed [14:0] phi;
        logic               overlap;
        logic               hit_en;
        logic               muon;
        logic [32:0]        dist_sq;
    } token_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic write;
        logic active;
    } cell_ctl_t;

    // Finishes the distance test carried by a token.
    function automatic logic token_hit(token_t tok, logic [29:0] rsq_e, logic [29:0] rsq_m);
        logic [29:0] rsq;
        rsq = tok.muon ? rsq_m : rsq_e;
        return tok.hit_en && (tok.dist_sq < {3'b000, rsq});
    endfunction

endpackage

FILE: rtl/fljo_cell.sv
// One cell of the lepton chain: holds a lepton and tests the passing jet against it.
module fljo_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  fljo_pkg::cell_ctl_t ctl,
    input  fljo_pkg::lepton_t   wr_entry,
    input  logic [29:0]         rsq_e,
    input  logic [29:0]         rsq_m,
    input  fljo_pkg::token_t    tok_in,
    output fljo_pkg::token_t    tok_out
);

    fljo_pkg::lepton_t entry_reg;
    fljo_pkg::token_t  tok_reg;
    fljo_pkg::token_t  tok_next;

    logic signed [16:0] deta;
    logic signed [16:0] dphi;
    logic signed [16:0] adphi;
    logic signed [16:0] wphi;
    logic signed [33:0] deta_sq;
    logic signed [33:0] dphi_sq;
    logic [32:0]        dist_sq;

    // Differences to the stored lepton, with phi wrapped at pi.
    always_comb
    begin
        deta  = {tok_in.eta[15], tok_in.eta} - {entry_reg.eta[15], entry_reg.eta};
        dphi  = {{2{tok_in.phi[14]}}, tok_in.phi} - {{2{entry_reg.phi[14]}}, entry_reg.phi};
        adphi = dphi[16] ? -dphi : dphi;
        wphi  = (adphi > fljo_pkg::PHI_PI) ? (fljo_pkg::PHI_TWO_PI - adphi) : adphi;
    end

    // Squared distance; the next cell or the top level finishes the compare.
    always_comb
    begin
        deta_sq = deta * deta;
        dphi_sq = wphi * wphi;
        dist_sq = {1'b0, deta_sq[31:0]} + {1'b0, dphi_sq[31:0]};
    end

    // Token handed on to the neighbour, folding in the previous cell's test.
    always_comb
    begin
        tok_next         = tok_in;
        tok_next.overlap = tok_in.overlap | fljo_pkg::token_hit(tok_in, rsq_e, rsq_m);
        tok_next.hit_en  = ctl.active;
        tok_next.muon    = entry_reg.is_muon;
        tok_next.dist_sq = dist_sq;
    end

    // Stored lepton, written when this cell is the next free slot.
    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            entry_reg <= wr_entry;
        end
    end

    // Token register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/fiducial_lepton_jet_overlap_filter.sv
// Top level of the fiducial lepton selection and jet-lepton overlap filter.
//
// Channel        Signals                                   Direction  Handshake
// item           start, busy, mode, pt, eta, phi           in         start && !busy
// result         done, kind, accepted, store_full,         out        done, one cycle
//                lepton_total
// configuration  cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// Electron, muon and end-of-event results come in the cycle after acceptance, and one
// may be accepted every cycle while busy is low. A jet walks the chain of LEPTON_DEPTH
// cells, one cell per cycle, and its result is registered as it leaves the last cell;
// busy stays high meanwhile. Reset empties the store and loads the default thresholds.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fiducial_lepton_jet_overlap_filter #(
    parameter int LEPTON_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [23:0] pt,
    input  logic [15:0] eta,
    input  logic [14:0] phi,
    output logic        done,
    output logic [1:0]  kind,
    output logic        accepted,
    output logic        store_full,
    output logic [6:0]  lepton_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int CW = $clog2(LEPTON_DEPTH + 1);

    // Configuration registers.
    logic [23:0] ele_pt_min_reg;
    logic [14:0] ele_eta_max_reg;
    logic [23:0] mu_pt_min_reg;
    logic [14:0] mu_eta_max_reg;
    logic [14:0] ele_radius_reg;
    logic [14:0] mu_radius_reg;
    logic        overlap_en_reg;
    logic [29:0] rsq_e_reg;
    logic [29:0] rsq_m_reg;

    // Control and result registers.
    logic [CW-1:0] count_reg, count_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [1:0]    kind_reg, kind_next;
    logic          accepted_reg, accepted_next;
    logic          full_reg, full_next;
    logic [6:0]    total_reg, total_next;

    logic              item_acc;
    logic              is_lepton;
    logic              is_muon;
    logic [15:0]       abs_eta;
    logic              fiducial;
    logic              room;
    logic              store_wr;
    fljo_pkg::lepton_t new_lepton;
    fljo_pkg::token_t  head_tok;
    fljo_pkg::token_t  chain [0:LEPTON_DEPTH];
    fljo_pkg::token_t  last_tok;
    logic [LEPTON_DEPTH:0] tok_valid;

    assign item_acc  = start && !busy_reg;
    assign cfg_ready = !busy_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ele_pt_min_reg  <= 24'd7000;
            ele_eta_max_reg <= 15'd10117;
            mu_pt_min_reg   <= 24'd5000;
            mu_eta_max_reg  <= 15'd11059;
            ele_radius_reg  <= 15'd819;
            mu_radius_reg   <= 15'd410;
            overlap_en_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fljo_pkg::CFG_ELE_PT_MIN:  ele_pt_min_reg  <= cfg_data;
                fljo_pkg::CFG_ELE_ETA_MAX: ele_eta_max_reg <= cfg_data[14:0];
                fljo_pkg::CFG_MU_PT_MIN:   mu_pt_min_reg   <= cfg_data;
                fljo_pkg::CFG_MU_ETA_MAX:  mu_eta_max_reg  <= cfg_data[14:0];
                fljo_pkg::CFG_ELE_RADIUS:  ele_radius_reg  <= cfg_data[14:0];
                fljo_pkg::CFG_MU_RADIUS:   mu_radius_reg   <= cfg_data[14:0];
                fljo_pkg::CFG_OVERLAP_EN:  overlap_en_reg  <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Squared radii, refreshed every cycle from the radius registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsq_e_reg <= 30'd670761;
            rsq_m_reg <= 30'd168100;
        end
        else
        begin
            rsq_e_reg <= ele_radius_reg * ele_radius_reg;
            rsq_m_reg <= mu_radius_reg * mu_radius_reg;
        end
    end

    // Fiducial test for an incoming lepton, and its store write when there is room.
    always_comb
    begin
        is_lepton = (mode == fljo_pkg::MODE_ELECTRON) || (mode == fljo_pkg::MODE_MUON);
        is_muon   = (mode == fljo_pkg::MODE_MUON);
        abs_eta   = eta[15] ? (~eta + 16'd1) : eta;
        if (is_muon)
        begin
            fiducial = (pt >= mu_pt_min_reg) && (abs_eta <= {1'b0, mu_eta_max_reg});
        end
        else
        begin
            fiducial = (pt >= ele_pt_min_reg) && (abs_eta <= {1'b0, ele_eta_max_reg});
        end
        room     = count_reg < CW'(LEPTON_DEPTH);
        store_wr = item_acc && is_lepton && fiducial && room;
        new_lepton.is_muon = is_muon;
        new_lepton.eta     = eta;
        new_lepton.phi     = phi;
    end

    // Lepton count: grows on a store, cleared at end of event.
    always_comb
    begin
        count_next = count_reg;
        priority if (store_wr)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (item_acc && (mode == fljo_pkg::MODE_END))
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Jet token entering the chain.
    always_comb
    begin
        head_tok       = '0;
        head_tok.valid = item_acc && (mode == fljo_pkg::MODE_JET);
        head_tok.eta   = eta;
        head_tok.phi   = phi;
    end

    assign chain[0] = head_tok;

    // The chain of cells, one per store slot.
    for (genvar i = 0; i < LEPTON_DEPTH; i++)
    begin : g_cell
        fljo_pkg::cell_ctl_t ctl;

        assign ctl = '{write:  store_wr && (count_reg == CW'(i)),
                       active: overlap_en_reg && (CW'(i) < count_reg)};

        fljo_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .wr_entry (new_lepton),
            .rsq_e    (rsq_e_reg),
            .rsq_m    (rsq_m_reg),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    for (genvar i = 0; i <= LEPTON_DEPTH; i++)
    begin : g_valid
        assign tok_valid[i] = chain[i].valid;
    end

    assign last_tok = chain[LEPTON_DEPTH];

    // Busy covers a jet's walk along the chain.
    always_comb
    begin
        busy_next = busy_reg;
        priority if (head_tok.valid)
        begin
            busy_next = 1'b1;
        end
        else if (last_tok.valid)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            busy_next = busy_reg;
        end
    end

    // Result selection: a finished jet, or an item that completes at once.
    always_comb
    begin
        done_next     = 1'b0;
        kind_next     = kind_reg;
        accepted_next = accepted_reg;
        full_next     = full_reg;
        total_next    = total_reg;
        priority if (last_tok.valid)
        begin
            done_next     = 1'b1;
            kind_next     = fljo_pkg::MODE_JET;
            accepted_next = !(last_tok.overlap
                              | fljo_pkg::token_hit(last_tok, rsq_e_reg, rsq_m_reg));
            full_next     = 1'b0;
            total_next    = 7'(count_reg);
        end
        else if (item_acc && (mode != fljo_pkg::MODE_JET))
        begin
            done_next     = 1'b1;
            kind_next     = mode;
            accepted_next = is_lepton && fiducial;
            full_next     = is_lepton && fiducial && !room;
            total_next    = 7'(count_next);
        end
        else
        begin
            done_next     = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        accepted_reg <= accepted_next;
        full_reg     <= full_next;
        total_reg    <= total_next;
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign kind         = kind_reg;
    assign accepted     = accepted_reg;
    assign store_full   = full_reg;
    assign lepton_total = total_reg;

    // The store never holds more leptons than it has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LEPTON_DEPTH))
        else $error("lepton count exceeds store depth");

    // Only one jet is ever in flight along the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid) <= 1)
        else $error("more than one jet token in the chain");

    // When busy falls, the jet's result is being shown.
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (done_reg && (kind_reg == fljo_pkg::MODE_JET)))
        else $error("busy fell without a jet result");

    // A full store is flagged only for an accepted lepton.
    a_full_lepton: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && full_reg) |-> (accepted_reg && ((kind_reg == fljo_pkg::MODE_ELECTRON)
                                                     || (kind_reg == fljo_pkg::MODE_MUON))))
        else $error("store full flagged on a non-lepton result");

    // Acceptance of a jet raises busy in the next cycle.
    a_jet_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && (mode == fljo_pkg::MODE_JET)) |=> busy_reg)
        else $error("busy not raised for a jet");

endmodule

FILE: test/fiducial_lepton_jet_overlap_filter_tb.sv
// Self-checking testbench for the fiducial lepton selection and jet-lepton overlap filter.
`timescale 1ns / 1ps

module fiducial_lepton_jet_overlap_filter_tb;

    localparam int LEPTON_DEPTH = 16;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 205;

    // One input item as it is driven onto the item ports.
    typedef struct packed {
        fljo_pkg::mode_t    mode;
        logic [23:0]        pt;
        logic signed [15:0] eta;
        logic signed [14:0] phi;
    } filter_item_t;

    // One result as it appears on the result ports.
    typedef struct packed {
        logic [1:0] kind;
        logic       accepted;
        logic       store_full;
        logic [6:0] lepton_total;
    } filter_result_t;

    // A row of the directed table; the result is typed in only where known is set.
    typedef struct packed {
        fljo_pkg::mode_t    mode;
        logic [23:0]        pt;
        logic signed [15:0] eta;
        logic signed [14:0] phi;
        logic               known;
        logic               acc;
        logic               full;
        logic [6:0]         total;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 17;

    // Directed table, all with the thresholds and radii loaded by reset.
    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        '{fljo_pkg::MODE_END, 24'd0, 16'sd0, 15'sd0, 1'b1, 1'b0, 1'b0, 7'd0},
        '{fljo_pkg::MODE_JET, 24'd0, 16'sd0, 15'sd0, 1'b1, 1'b1, 1'b0, 7'd0},
        '{fljo_pkg::MODE_ELECTRON, 24'd7000, 16'sd10117, 15'sd0, 1'b1, 1'b1, 1'b0, 7'd1},
        '{fljo_pkg::MODE_ELECTRON, 24'd6999, 16'sd0, 15'sd0, 1'b1, 1'b0, 1'b0, 7'd1},
        '{fljo_pkg::MODE_ELECTRON, 24'hFFFFFF, -16'sd10118, 15'sd0, 1'b1, 1'b0, 1'b0, 7'd1},
        '{fljo_pkg::MODE_MUON, 24'd5000, -16'sd11059, 15'sd12868, 1'b1, 1'b1, 1'b0, 7'd2},
        '{fljo_pkg::MODE_MUON, 24'd4999, 16'sd0, 15'sd0, 1'b1, 1'b0, 1'b0, 7'd2},
        '{fljo_pkg::MODE_MUON, 24'hFFFFFF, 16'sd11060, 15'sd0, 1'b1, 1'b0, 1'b0, 7'd2},
        '{fljo_pkg::MODE_JET, 24'd30000, 16'sd10117, 15'sd0, 1'b1, 1'b0, 1'b0, 7'd2},
        '{fljo_pkg::MODE_JET, 24'd30000, 16'sd10936, 15'sd0, 1'b0, 1'b0, 1'b0, 7'd0},
        '{fljo_pkg::MODE_JET, 24'd30000, 16'sd10935, 15'sd0, 1'b0, 1'b0, 1'b0, 7'd0},
        '{fljo_pkg::MODE_JET, 24'hFFFFFF, -16'sd11059, -15'sd12868, 1'b0, 1'b0, 1'b0, 7'd0},
        '{fljo_pkg::MODE_JET, 24'd1, -16'sd32768, -15'sd16384, 1'b0, 1'b0, 1'b0, 7'd0},
        '{fljo_pkg::MODE_ELECTRON, 24'hFFFFFF, 16'sd32767, 15'sd16383, 1'b1, 1'b0, 1'b0, 7'd2},
        '{fljo_pkg::MODE_MUON, 24'd5000, -16'sd32768, -15'sd16384, 1'b1, 1'b0, 1'b0, 7'd2},
        '{fljo_pkg::MODE_END, 24'hFFFFFF, -16'sd1, -15'sd1, 1'b1, 1'b0, 1'b0, 7'd0},
        '{fljo_pkg::MODE_JET, 24'd20000, -16'sd11059, -15'sd12868, 1'b1, 1'b1, 1'b0, 7'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = '0;
    logic [23:0] pt = '0;
    logic [15:0] eta = '0;
    logic [14:0] phi = '0;
    logic        done;
    logic [1:0]  kind;
    logic        accepted;
    logic        store_full;
    logic [6:0]  lepton_total;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // Thresholds and store as the block should hold them.
    logic [23:0]       ele_pt_min;
    logic [14:0]       ele_eta_max;
    logic [23:0]       mu_pt_min;
    logic [14:0]       mu_eta_max;
    logic [14:0]       ele_radius;
    logic [14:0]       mu_radius;
    logic              overlap_on;
    fljo_pkg::lepton_t stored_leptons [LEPTON_DEPTH];
    int                stored_count;

    filter_result_t pending_results [$];

    int idle_pct = 0;
    int err_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int jets_removed = 0;
    int full_flags = 0;
    int settings_used = 1;

    fiducial_lepton_jet_overlap_filter #(
        .LEPTON_DEPTH(LEPTON_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .pt(pt),
        .eta(eta),
        .phi(phi),
        .done(done),
        .kind(kind),
        .accepted(accepted),
        .store_full(store_full),
        .lepton_total(lepton_total),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still expected.", pending_results.size());
        $display("fiducial_lepton_jet_overlap_filter_tb NOT OK");
        $finish;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Works out the result of one item and advances the lepton store.
    function automatic filter_result_t filter_outcome(filter_item_t it);
        filter_result_t res;
        bit             is_mu;
        int             abs_eta;
        logic [23:0]    pt_cut;
        logic [14:0]    eta_cut;
        longint         deta;
        longint         dphi;
        longint         rad;

        res.kind = it.mode;
        res.accepted = 1'b0;
        res.store_full = 1'b0;
        case (it.mode)
            fljo_pkg::MODE_ELECTRON, fljo_pkg::MODE_MUON:
            begin
                is_mu = (it.mode == fljo_pkg::MODE_MUON);
                abs_eta = (it.eta < 0) ? -int'(it.eta) : int'(it.eta);
                pt_cut = is_mu ? mu_pt_min : ele_pt_min;
                eta_cut = is_mu ? mu_eta_max : ele_eta_max;
                if (it.pt >= pt_cut && abs_eta <= int'(eta_cut))
                begin
                    res.accepted = 1'b1;
                    if (stored_count < LEPTON_DEPTH)
                    begin
                        stored_leptons[stored_count] = '{is_mu, it.eta, it.phi};
                        stored_count++;
                    end
                    else
                    begin
                        res.store_full = 1'b1;
                    end
                end
            end
            fljo_pkg::MODE_JET:
            begin
                res.accepted = 1'b1;
                if (overlap_on)
                begin
                    for (int i = 0; i < stored_count; i++)
                    begin
                        deta = longint'(it.eta) - longint'(stored_leptons[i].eta);
                        dphi = longint'(it.phi) - longint'(stored_leptons[i].phi);
                        if (dphi < 0)
                            dphi = -dphi;
                        // Wrap at pi; beyond two pi the wrapped value goes negative.
                        if (dphi > longint'(fljo_pkg::PHI_PI))
                            dphi = longint'(fljo_pkg::PHI_TWO_PI) - dphi;
                        rad = stored_leptons[i].is_muon ? longint'(mu_radius)
                                                        : longint'(ele_radius);
                        if (deta * deta + dphi * dphi < rad * rad)
                            res.accepted = 1'b0;
                    end
                end
            end
            default:
            begin
                stored_count = 0;
            end
        endcase
        res.lepton_total = 7'(stored_count);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("Mismatch at result %0d, %s: got %0d, expected %0d",
                 results_checked, what, got, want);
    endtask

    // Checks each result against the oldest expectation.
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, kind", kind, -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (accepted !== want.accepted)
                    report_mismatch("accepted", accepted, want.accepted);
                if (store_full !== want.store_full)
                    report_mismatch("store_full", store_full, want.store_full);
                if (lepton_total !== want.lepton_total)
                    report_mismatch("lepton_total", lepton_total, want.lepton_total);
                if (want.kind == fljo_pkg::MODE_JET && !want.accepted)
                    jets_removed++;
                if (want.store_full)
                    full_flags++;
            end
            results_checked++;
        end
    end

    // Drives one item, waits for its transaction and records the expectation.
    task automatic send_item(filter_item_t it, bit known, filter_result_t typed_res);
        int             gap;
        filter_result_t predicted;
        filter_result_t expected;

        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= it.mode;
        pt <= it.pt;
        eta <= it.eta;
        phi <= it.phi;
        do
            @(posedge clk);
        while (busy);
        predicted = filter_outcome(it);
        expected = known ? typed_res : predicted;
        pending_results = {pending_results, expected};
        items_sent++;
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_for_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LEPTON_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_register(fljo_pkg::cfg_index_t idx, logic [23:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            fljo_pkg::CFG_ELE_PT_MIN:  ele_pt_min = value;
            fljo_pkg::CFG_ELE_ETA_MAX: ele_eta_max = value[14:0];
            fljo_pkg::CFG_MU_PT_MIN:   mu_pt_min = value;
            fljo_pkg::CFG_MU_ETA_MAX:  mu_eta_max = value[14:0];
            fljo_pkg::CFG_ELE_RADIUS:  ele_radius = value[14:0];
            fljo_pkg::CFG_MU_RADIUS:   mu_radius = value[14:0];
            fljo_pkg::CFG_OVERLAP_EN:  overlap_on = value[0];
            default:                   ;
        endcase
    endtask

    // Loads the thresholds for one phase: extremes first, then random settings.
    task automatic configure_phase(int phase);
        logic [23:0] v_ept;
        logic [23:0] v_eeta;
        logic [23:0] v_mpt;
        logic [23:0] v_meta;
        logic [23:0] v_erad;
        logic [23:0] v_mrad;
        logic [23:0] v_ovl;

        case (phase)
            1:
            begin
                v_ept = 24'd0;
                v_eeta = 24'd0;
                v_mpt = 24'd0;
                v_meta = 24'd0;
                v_erad = 24'd0;
                v_mrad = 24'd0;
                v_ovl = 24'd1;
            end
            2:
            begin
                v_ept = 24'hFFFFFF;
                v_eeta = 24'd20480;
                v_mpt = 24'hFFFFFF;
                v_meta = 24'd20480;
                v_erad = 24'd16384;
                v_mrad = 24'd16384;
                v_ovl = 24'd1;
            end
            default:
            begin
                v_ept = 24'($urandom_range(0, 20000));
                v_eeta = 24'($urandom_range(0, 20480));
                v_mpt = 24'($urandom_range(0, 20000));
                v_meta = 24'($urandom_range(0, 20480));
                v_erad = 24'($urandom_range(0, (phase < 6) ? 4000 : 16384));
                v_mrad = 24'($urandom_range(0, (phase < 6) ? 4000 : 16384));
                v_ovl = (phase == 3) ? 24'd0 : 24'd1;
            end
        endcase
        write_register(fljo_pkg::CFG_ELE_PT_MIN, v_ept);
        write_register(fljo_pkg::CFG_ELE_ETA_MAX, v_eeta);
        write_register(fljo_pkg::CFG_MU_PT_MIN, v_mpt);
        write_register(fljo_pkg::CFG_MU_ETA_MAX, v_meta);
        write_register(fljo_pkg::CFG_ELE_RADIUS, v_erad);
        write_register(fljo_pkg::CFG_MU_RADIUS, v_mrad);
        write_register(fljo_pkg::CFG_OVERLAP_EN, v_ovl);
        settings_used++;
    endtask

    // A lepton aimed at the current cuts, mostly fiducial, often on an edge.
    function automatic filter_item_t make_lepton(bit is_mu);
        filter_item_t it;
        int           ptmin;
        int           etamax;
        int           p;
        int           e;
        int           ph;
        int           sel;

        ptmin = is_mu ? int'(mu_pt_min) : int'(ele_pt_min);
        etamax = is_mu ? int'(mu_eta_max) : int'(ele_eta_max);
        it.mode = is_mu ? fljo_pkg::MODE_MUON : fljo_pkg::MODE_ELECTRON;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            p = ptmin + int'($urandom_range(0, 40000));
        else if (sel == 6)
            p = ptmin - 1;
        else if (sel == 7)
            p = ptmin;
        else if (sel == 8)
            p = int'($urandom_range(0, 24'hFFFFFF));
        else
            p = 0;
        sel = $urandom_range(0, 9);
        if (sel <= 6)
            e = int'($urandom_range(0, 2 * etamax)) - etamax;
        else if (sel == 7)
            e = etamax;
        else if (sel == 8)
            e = etamax + 1;
        else
            e = int'($urandom_range(0, 65535)) - 32768;
        if (sel >= 7 && sel <= 8 && $urandom_range(0, 1))
            e = -e;
        if ($urandom_range(0, 9) < 8)
            ph = int'($urandom_range(0, 25736)) - 12868;
        else
            ph = int'($urandom_range(0, 32767)) - 16384;
        it.pt = 24'(clamp_int(p, 0, 24'hFFFFFF));
        it.eta = 16'(clamp_int(e, -32768, 32767));
        it.phi = 15'(ph);
        return it;
    endfunction

    // A jet, either scattered around a lepton of the event or placed at random.
    function automatic filter_item_t make_jet(bit aimed, fljo_pkg::lepton_t target);
        filter_item_t it;
        int           rad;
        int           span;
        int           de;
        int           dp;
        int           e;
        int           ph;

        it.mode = fljo_pkg::MODE_JET;
        it.pt = 24'($urandom);
        if (aimed)
        begin
            rad = target.is_muon ? int'(mu_radius) : int'(ele_radius);
            span = rad + rad / 2 + 2;
            if ($urandom_range(0, 9) == 0)
            begin
                // Exactly on the radius, which must not count as an overlap.
                de = $urandom_range(0, 1) ? rad : -rad;
                dp = 0;
            end
            else
            begin
                de = int'($urandom_range(0, 2 * span)) - span;
                dp = int'($urandom_range(0, 2 * span)) - span;
            end
            e = int'(target.eta) + de;
            ph = int'(target.phi) + dp;
            // Sometimes carry the jet across the pi boundary.
            if ($urandom_range(0, 1))
            begin
                if (ph > 12868)
                    ph -= 25736;
                else if (ph < -12868)
                    ph += 25736;
            end
            if (ph > 16383)
                ph -= 25736;
            if (ph < -16384)
                ph += 25736;
        end
        else
        begin
            e = int'($urandom_range(0, 40960)) - 20480;
            ph = int'($urandom_range(0, 25736)) - 12868;
        end
        it.eta = 16'(clamp_int(e, -32768, 32767));
        it.phi = 15'(ph);
        return it;
    endfunction

    // One event: leptons and jets interleaved, closed by an end-of-event item
    // most of the time; a few are plain noise items instead.
    task automatic send_event();
        fljo_pkg::lepton_t seen [$];
        fljo_pkg::lepton_t target;
        fljo_pkg::lepton_t fresh;
        int                n_lep;
        int                n_jet;
        bit                is_mu;
        bit                aimed;
        filter_item_t      it;
        filter_result_t    none;

        none = '0;
        if ($urandom_range(0, 9) == 0)
        begin
            it.mode = fljo_pkg::mode_t'($urandom_range(0, 3));
            it.pt = 24'($urandom);
            it.eta = 16'($urandom);
            it.phi = 15'($urandom);
            send_item(it, 1'b0, none);
        end
        else
        begin
            n_lep = ($urandom_range(0, 99) < 15) ? $urandom_range(20, 34) : $urandom_range(0, 5);
            n_jet = $urandom_range(0, 6);
            while (n_lep + n_jet > 0)
            begin
                if (n_lep > 0 && (n_jet == 0 || $urandom_range(0, 2) != 0))
                begin
                    is_mu = 1'($urandom_range(0, 1));
                    it = make_lepton(is_mu);
                    fresh = '{is_mu, it.eta, it.phi};
                    seen = {seen, fresh};
                    n_lep--;
                end
                else
                begin
                    aimed = 1'b0;
                    target = '0;
                    if (seen.size() > 0 && $urandom_range(0, 9) < 7)
                    begin
                        aimed = 1'b1;
                        target = seen[$urandom_range(0, seen.size() - 1)];
                    end
                    it = make_jet(aimed, target);
                    n_jet--;
                end
                send_item(it, 1'b0, none);
            end
            // A missing end-of-event lets the store run on into the next event.
            if ($urandom_range(0, 9) != 0)
            begin
                it.mode = fljo_pkg::MODE_END;
                it.pt = 24'($urandom);
                it.eta = 16'($urandom);
                it.phi = 15'($urandom);
                send_item(it, 1'b0, none);
            end
        end
    endtask

    // Main sequence: reset, directed table, then random phases.
    initial
    begin
        int             phase_first;
        filter_item_t   it;
        filter_result_t typed_res;

        ele_pt_min = 24'd7000;
        ele_eta_max = 15'd10117;
        mu_pt_min = 24'd5000;
        mu_eta_max = 15'd11059;
        ele_radius = 15'd819;
        mu_radius = 15'd410;
        overlap_on = 1'b1;
        stored_count = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            it = '{directed_rows[r].mode, directed_rows[r].pt,
                   directed_rows[r].eta, directed_rows[r].phi};
            typed_res = '{directed_rows[r].mode, directed_rows[r].acc,
                          directed_rows[r].full, directed_rows[r].total};
            send_item(it, directed_rows[r].known, typed_res);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                wait_for_idle();
                configure_phase(phase);
            end
            case (phase % 4)
                1:       idle_pct = 45;
                3:       idle_pct = 25;
                default: idle_pct = 0;
            endcase
            phase_first = items_sent;
            while (items_sent - phase_first < PHASE_ITEMS)
                send_event();
        end

        wait_for_idle();
        $display("Sent %0d items under %0d threshold settings, %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("Jets removed by overlap: %0d, leptons refused by a full store: %0d.",
                 jets_removed, full_flags);
        if (err_count == 0 && pending_results.size() == 0)
            $display("fiducial_lepton_jet_overlap_filter_tb OK");
        else
            $display("fiducial_lepton_jet_overlap_filter_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fljo_pkg.sv
rtl/fljo_cell.sv
rtl/fiducial_lepton_jet_overlap_filter.sv
test/fiducial_lepton_jet_overlap_filter_tb.sv
